// File: src/mldb_pkg.sv
// Shared types and constants for the multi-lamp duty blinker.
package mldb_pkg;

  // Six lamp slots exist in the register map and on the drive port
  localparam int LAMP_SLOTS    = 6;
  localparam int PERIOD_BITS   = 16;
  localparam int MODE_BITS     = 3;
  localparam int REG_ADDR_BITS = 5;
  localparam int REG_IDX_BITS  = 3;
  localparam int DATA_BITS     = 32;

  // Register indexes on the configuration port
  localparam logic [REG_IDX_BITS-1:0] REG_ENABLE  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_MODES   = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_PERIOD0 = 3'd2;

  // Duty ratio modes
  typedef enum logic [MODE_BITS-1:0] {
    MODE_STEADY        = 3'd0,
    MODE_HALF          = 3'd1,
    MODE_THIRD         = 3'd2,
    MODE_SIXTH         = 3'd3,
    MODE_ELEVENTH      = 3'd4,
    MODE_TWO_THIRDS    = 3'd5,
    MODE_FIVE_SIXTHS   = 3'd6,
    MODE_TEN_ELEVENTHS = 3'd7
  } mode_t;

  // Per-lamp configuration handed from the register file to a lamp lane
  typedef struct packed {
    logic                   enable;
    logic [MODE_BITS-1:0]   mode;
    logic [PERIOD_BITS-1:0] period;
  } lamp_cfg_t;

endpackage

// File: src/mldb_regs.sv
// APB register file: enable mask, ratio modes and six lamp periods.
module mldb_regs (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         psel,
  input  logic                                         penable,
  input  logic                                         pwrite,
  input  logic [mldb_pkg::REG_ADDR_BITS-1:0]           paddr,
  input  logic [mldb_pkg::DATA_BITS-1:0]               pwdata,
  output logic [mldb_pkg::DATA_BITS-1:0]               prdata,
  output logic                                         pready,
  output mldb_pkg::lamp_cfg_t [mldb_pkg::LAMP_SLOTS-1:0] cfg
);

  logic [mldb_pkg::LAMP_SLOTS-1:0]              enable_mask;
  logic [mldb_pkg::LAMP_SLOTS*mldb_pkg::MODE_BITS-1:0] ratio_modes;
  logic [mldb_pkg::PERIOD_BITS-1:0]             period [mldb_pkg::LAMP_SLOTS];

  logic [mldb_pkg::REG_IDX_BITS-1:0] reg_idx;
  logic [mldb_pkg::REG_IDX_BITS-1:0] period_idx;
  logic                              wr_en;

  assign pready     = 1'b1;
  assign reg_idx    = paddr[mldb_pkg::REG_ADDR_BITS-1:2];
  assign period_idx = reg_idx - mldb_pkg::REG_PERIOD0;
  assign wr_en      = psel && penable && pwrite && pready;

  // Write the addressed register at the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= '0;
      ratio_modes <= '0;
      for (int i = 0; i < mldb_pkg::LAMP_SLOTS; i++) begin
        period[i] <= '0;
      end
    end else if (wr_en) begin
      case (reg_idx)
        mldb_pkg::REG_ENABLE: enable_mask <= pwdata[mldb_pkg::LAMP_SLOTS-1:0];
        mldb_pkg::REG_MODES:  ratio_modes <= pwdata[mldb_pkg::LAMP_SLOTS*mldb_pkg::MODE_BITS-1:0];
        default:              period[period_idx] <= pwdata[mldb_pkg::PERIOD_BITS-1:0];
      endcase
    end
  end

  // Return the addressed register, zero extended
  always_comb begin
    case (reg_idx)
      mldb_pkg::REG_ENABLE: prdata = mldb_pkg::DATA_BITS'(enable_mask);
      mldb_pkg::REG_MODES:  prdata = mldb_pkg::DATA_BITS'(ratio_modes);
      default:              prdata = mldb_pkg::DATA_BITS'(period[period_idx]);
    endcase
  end

  // Split the registers into per-lamp settings
  always_comb begin
    for (int n = 0; n < mldb_pkg::LAMP_SLOTS; n++) begin
      cfg[n].enable = enable_mask[n];
      cfg[n].mode   = ratio_modes[n*mldb_pkg::MODE_BITS +: mldb_pkg::MODE_BITS];
      cfg[n].period = period[n];
    end
  end

endmodule

// File: src/mldb_reload.sv
// Phase duration of one lamp: period divided by 2, 3, 6 or 11, times a ratio, or the whole period in steady mode.
module mldb_reload #(
  parameter int COUNT_BITS = 16
) (
  input  logic [mldb_pkg::PERIOD_BITS-1:0] period,
  input  logic [mldb_pkg::MODE_BITS-1:0]   mode,
  input  logic                             on_phase,
  output logic [COUNT_BITS-1:0]            reload
);

  // Reciprocals that give exact truncating quotients for 16-bit periods
  localparam int RECIP3_SHIFT  = 17;
  localparam int RECIP11_SHIFT = 19;
  localparam int PROD3_BITS    = mldb_pkg::PERIOD_BITS + RECIP3_SHIFT;
  localparam int PROD11_BITS   = mldb_pkg::PERIOD_BITS + RECIP11_SHIFT;
  localparam logic [PROD3_BITS-1:0]  RECIP3  = PROD3_BITS'(((1 << RECIP3_SHIFT) + 2) / 3);
  localparam logic [PROD11_BITS-1:0] RECIP11 = PROD11_BITS'(((1 << RECIP11_SHIFT) + 10) / 11);
  localparam int WIDE_BITS = mldb_pkg::PERIOD_BITS + 4;

  logic [PROD3_BITS-1:0]            prod3;
  logic [PROD11_BITS-1:0]           prod11;
  logic [mldb_pkg::PERIOD_BITS-1:0] q2, q3, q6, q11;
  mldb_pkg::mode_t                  eff_mode;
  logic [WIDE_BITS-1:0]             span;

  // Constant divisions by reciprocal multiply; sixths come from thirds
  assign prod3  = PROD3_BITS'(period) * RECIP3;
  assign prod11 = PROD11_BITS'(period) * RECIP11;
  assign q2     = period >> 1;
  assign q3     = prod3[RECIP3_SHIFT +: mldb_pkg::PERIOD_BITS];
  assign q6     = q3 >> 1;
  assign q11    = prod11[RECIP11_SHIFT +: mldb_pkg::PERIOD_BITS];

  // Off phase takes the on time of the partner ratio
  always_comb begin
    eff_mode = mldb_pkg::mode_t'(mode);
    if (!on_phase) begin
      case (mldb_pkg::mode_t'(mode))
        mldb_pkg::MODE_THIRD:         eff_mode = mldb_pkg::MODE_TWO_THIRDS;
        mldb_pkg::MODE_SIXTH:         eff_mode = mldb_pkg::MODE_FIVE_SIXTHS;
        mldb_pkg::MODE_ELEVENTH:      eff_mode = mldb_pkg::MODE_TEN_ELEVENTHS;
        mldb_pkg::MODE_TWO_THIRDS:    eff_mode = mldb_pkg::MODE_THIRD;
        mldb_pkg::MODE_FIVE_SIXTHS:   eff_mode = mldb_pkg::MODE_SIXTH;
        mldb_pkg::MODE_TEN_ELEVENTHS: eff_mode = mldb_pkg::MODE_ELEVENTH;
        default:                      eff_mode = mldb_pkg::mode_t'(mode);
      endcase
    end
  end

  // Pick the quotient and scale it with shifts and adds
  always_comb begin
    case (eff_mode)
      mldb_pkg::MODE_HALF:          span = WIDE_BITS'(q2);
      mldb_pkg::MODE_THIRD:         span = WIDE_BITS'(q3);
      mldb_pkg::MODE_SIXTH:         span = WIDE_BITS'(q6);
      mldb_pkg::MODE_ELEVENTH:      span = WIDE_BITS'(q11);
      mldb_pkg::MODE_TWO_THIRDS:    span = WIDE_BITS'(q3) << 1;
      mldb_pkg::MODE_FIVE_SIXTHS:   span = (WIDE_BITS'(q6) << 2) + WIDE_BITS'(q6);
      mldb_pkg::MODE_TEN_ELEVENTHS: span = (WIDE_BITS'(q11) << 3) + (WIDE_BITS'(q11) << 1);
      default:                      span = WIDE_BITS'(period);
    endcase
  end

  assign reload = span[COUNT_BITS-1:0];

endmodule

// File: src/mldb_lamp.sv
// One lamp lane: countdown, phase and drive bit, updated once per item.
module mldb_lamp #(
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                elapsed,
  input  mldb_pkg::lamp_cfg_t cfg,
  output logic                lit_next
);

  logic                  phase;
  logic                  lit;
  logic [COUNT_BITS-1:0] countdown;

  logic                  phase_next;
  logic [COUNT_BITS-1:0] countdown_next;
  logic [COUNT_BITS-1:0] count_dec;
  logic [COUNT_BITS-1:0] reload;

  // Duration of the phase about to start
  mldb_reload #(
    .COUNT_BITS (COUNT_BITS)
  ) u_reload (
    .period   (cfg.period),
    .mode     (cfg.mode),
    .on_phase (!phase),
    .reload   (reload)
  );

  // Drop a nonzero countdown by one on an elapsed tick
  assign count_dec = (elapsed && (countdown != '0)) ? countdown - COUNT_BITS'(1) : countdown;

  // Resolve disable, steady and blink behavior
  always_comb begin
    phase_next     = phase;
    countdown_next = count_dec;
    lit_next       = lit;
    if (!cfg.enable) begin
      lit_next = 1'b0;
    end else if (mldb_pkg::mode_t'(cfg.mode) == mldb_pkg::MODE_STEADY) begin
      lit_next = 1'b1;
    end else if (count_dec == '0) begin
      phase_next     = !phase;
      lit_next       = !phase;
      countdown_next = reload;
    end
  end

  // Hold lane state between items
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      lit       <= 1'b0;
      countdown <= '0;
    end else if (advance) begin
      phase     <= phase_next;
      lit       <= lit_next;
      countdown <= countdown_next;
    end
  end

endmodule

// File: src/multi_lamp_duty_blinker.sv
// Multi-lamp duty blinker top level: input register, lamp lanes, result register.
//
// Drives up to six lamps, each with an enable bit, a duty ratio mode and a
// 16-bit period set over the APB port. Each transfer on the item channel
// carries one elapsed flag; every transfer produces exactly one lamp_drive
// result. The block takes one item per clock while the result channel is
// not stalled; each item is held in the input register and then passes
// through the lamp lanes into the result register. All lamp lanes
// update in parallel, and their constant-divider reload logic sets the
// critical path. Backpressure on the result channel stalls the input
// register and then the item channel. Configure only while idle.
module multi_lamp_duty_blinker #(
  parameter int LAMP_COUNT = 6,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // item channel
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic                              elapsed,
  // result channel
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [mldb_pkg::LAMP_SLOTS-1:0]   lamp_drive,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mldb_pkg::REG_ADDR_BITS-1:0] paddr,
  input  logic [mldb_pkg::DATA_BITS-1:0]    pwdata,
  output logic [mldb_pkg::DATA_BITS-1:0]    prdata,
  output logic                              pready
);

  mldb_pkg::lamp_cfg_t [mldb_pkg::LAMP_SLOTS-1:0] cfg;

  logic                            s1_valid;
  logic                            s1_elapsed;
  logic                            s1_fire;
  logic [mldb_pkg::LAMP_SLOTS-1:0] drive_next;
  logic [mldb_pkg::LAMP_SLOTS-1:0] enable_mask;
  logic [mldb_pkg::LAMP_SLOTS-1:0] steady_mask;

  mldb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the input register when the result register can take its result
  assign s1_fire    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_fire;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_elapsed <= elapsed;
    end
  end

  // Lamp lanes; slots past LAMP_COUNT stay dark
  for (genvar n = 0; n < mldb_pkg::LAMP_SLOTS; n++) begin : g_lamp
    if (n < LAMP_COUNT) begin : g_on
      mldb_lamp #(
        .COUNT_BITS (COUNT_BITS)
      ) u_lamp (
        .clk      (clk),
        .rst      (rst),
        .advance  (s1_fire),
        .elapsed  (s1_elapsed),
        .cfg      (cfg[n]),
        .lit_next (drive_next[n])
      );
      assign steady_mask[n] = cfg[n].enable &&
                              (mldb_pkg::mode_t'(cfg[n].mode) == mldb_pkg::MODE_STEADY);
    end else begin : g_off
      assign drive_next[n]  = 1'b0;
      assign steady_mask[n] = 1'b0;
    end
    assign enable_mask[n] = cfg[n].enable;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      lamp_drive <= drive_next;
    end
  end

  // Disabled lamps are dark in the result that follows
  assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> ((lamp_drive & ~$past(enable_mask)) == '0))
    else $error("disabled lamp driven");

  // Steady lamps are lit in the result that follows
  assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> ((lamp_drive & $past(steady_mask)) == $past(steady_mask)))
    else $error("steady lamp not lit");

  // Input stalls only when both stages are full and the result is held
  assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (s1_valid && result_valid && !result_ready))
    else $error("input stalled without backpressure");

  // A new result comes only from a held item
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_valid))
    else $error("result without item");

endmodule
